// ===== sv/ste_pkg.sv =====
// Shared types and constants for the symbol token expander.
// No dependencies.
`default_nettype none

package ste_pkg;

  localparam int unsigned TOKEN_STORE_BYTES_DEF = 4096;
  localparam int unsigned MAX_TOKEN_LEN_DEF     = 32;
  localparam int unsigned MAX_NAME_LEN_DEF      = 128;

  localparam int unsigned INDEX_SLOTS = 256;
  localparam int unsigned ADDR_W      = 12;
  localparam int unsigned VALUE_W     = 12;
  localparam int unsigned CHAR_W      = 8;
  localparam int unsigned SLOT_W      = 8;

  typedef enum logic [1:0] {
    MODE_TOKEN  = 2'd0,
    MODE_INDEX  = 2'd1,
    MODE_STREAM = 2'd2,
    MODE_RSVD   = 2'd3
  } ste_mode_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_INDEX,
    ST_WALK,
    ST_TERM
  } ste_state_e;

  typedef struct packed {
    logic [CHAR_W-1:0] char_out;
    logic              end_of_symbol;
    logic              last_of_item;
  } ste_result_t;

endpackage

`default_nettype wire

// ===== sv/ste_if.sv =====
// Valid/ready channel interfaces for input items and result beats.
// Depends on ste_pkg.
`default_nettype none

interface ste_in_if;
  import ste_pkg::*;

  logic               valid;
  logic               ready;
  ste_mode_e          mode;
  logic [ADDR_W-1:0]  address;
  logic [VALUE_W-1:0] value;

  modport source (output valid, output mode, output address, output value, input ready);
  modport sink   (input valid, input mode, input address, input value, output ready);
endinterface

interface ste_out_if;
  import ste_pkg::*;

  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] char_out;
  logic              end_of_symbol;
  logic              last_of_item;

  modport source (output valid, output char_out, output end_of_symbol, output last_of_item,
                  input ready);
  modport sink   (input valid, input char_out, input end_of_symbol, input last_of_item,
                  output ready);
endinterface

`default_nettype wire

// ===== sv/symbol_token_expander.sv =====
// Top level: token store, token index and expansion sequencer.
// Depends on ste_pkg, ste_if and ste_out_buf.
//
//   channel  dir  beat contents                          accepted when
//   in_i     in   mode, address, value                   valid && ready
//   out_o    out  char_out, end_of_symbol, last_of_item  valid && ready
//
// Load items and nonzero length bytes leave the sequencer idle; a zero length adds a terminator beat.
// A token code is handled in order: accept, index read, a read of each token
// byte up to the stop byte, and, after the last code, the terminator beats;
// the walk is serial over the token memory's single read port.
// Reset clears control state only; both memories hold garbage until loaded.
// A full result buffer stalls the walk in place; input is taken only when idle.
// TOKEN_STORE_BYTES must be a power of two.
`default_nettype none

module symbol_token_expander #(
  parameter int unsigned TOKEN_STORE_BYTES = ste_pkg::TOKEN_STORE_BYTES_DEF,
  parameter int unsigned MAX_TOKEN_LEN     = ste_pkg::MAX_TOKEN_LEN_DEF,
  parameter int unsigned MAX_NAME_LEN      = ste_pkg::MAX_NAME_LEN_DEF
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  ste_in_if.sink    in_i,
  ste_out_if.source out_o
);
  import ste_pkg::*;

  localparam int unsigned AW = $clog2(TOKEN_STORE_BYTES);
  localparam int unsigned CW = $clog2(MAX_TOKEN_LEN + 1);
  localparam int unsigned NW = $clog2(MAX_NAME_LEN);
  localparam logic [CW-1:0] TOK_LIM  = CW'(MAX_TOKEN_LEN);
  localparam logic [NW-1:0] NAME_LIM = NW'(MAX_NAME_LEN - 1);

  logic [CHAR_W-1:0]  token_store [TOKEN_STORE_BYTES];
  logic [VALUE_W-1:0] index_store [INDEX_SLOTS];

  ste_state_e        state_q, state_d;
  logic [7:0]        codes_left_q, codes_left_d;
  logic              awaiting_q, awaiting_d;
  logic              skipped_q, skipped_d;
  logic [NW-1:0]     name_sent_q, name_sent_d;
  logic              pend_q, pend_d;
  logic [CHAR_W-1:0] pend_char_q, pend_char_d;
  logic [AW-1:0]     addr_q, addr_d;
  logic [CW-1:0]     cnt_q, cnt_d;

  logic [CHAR_W-1:0]  tok_rdata_q;
  logic [VALUE_W-1:0] idx_rdata_q;
  logic [AW-1:0]      tok_raddr;
  logic [AW-1:0]      start_addr;
  logic [CHAR_W-1:0]  in_byte;
  logic               in_acc;
  logic               tok_valid;
  logic               emit_char;
  logic               stall;
  logic               push;
  ste_result_t        push_data;
  logic               push_ready;

  assign in_acc     = in_i.valid && in_i.ready;
  assign in_byte    = in_i.value[CHAR_W-1:0];
  assign start_addr = AW'(idx_rdata_q);
  assign tok_valid  = (tok_rdata_q != '0) && (cnt_q != TOK_LIM);
  assign emit_char  = tok_valid && skipped_q && (name_sent_q != NAME_LIM);

  // outputs of the sequencer
  always_comb begin
    in_i.ready = (state_q == ST_IDLE);
    push       = 1'b0;
    push_data  = '{char_out: pend_char_q, end_of_symbol: 1'b0, last_of_item: 1'b0};
    stall      = 1'b0;
    tok_raddr  = addr_q;
    case (state_q)
      ST_INDEX: begin
        tok_raddr = start_addr;
      end
      ST_WALK: begin
        if (tok_valid) begin
          if (emit_char && pend_q) begin
            push  = 1'b1;
            stall = !push_ready;
          end
          if (!stall) begin
            tok_raddr = addr_q + AW'(1);
          end
        end else if (codes_left_q != 8'd1 && pend_q) begin
          push                   = 1'b1;
          push_data.last_of_item = 1'b1;
          stall                  = !push_ready;
        end
      end
      ST_TERM: begin
        push = 1'b1;
        if (!pend_q) begin
          push_data = '{char_out: '0, end_of_symbol: 1'b1, last_of_item: 1'b1};
        end
      end
      default: ;
    endcase
  end

  // next state
  always_comb begin
    state_d      = state_q;
    codes_left_d = codes_left_q;
    awaiting_d   = awaiting_q;
    skipped_d    = skipped_q;
    name_sent_d  = name_sent_q;
    pend_d       = pend_q;
    pend_char_d  = pend_char_q;
    addr_d       = addr_q;
    cnt_d        = cnt_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc && in_i.mode == MODE_STREAM) begin
          if (awaiting_q) begin
            codes_left_d = in_byte;
            skipped_d    = 1'b0;
            name_sent_d  = '0;
            if (in_byte == '0) begin
              state_d = ST_TERM;
            end else begin
              awaiting_d = 1'b0;
            end
          end else begin
            state_d = ST_INDEX;
          end
        end
      end
      ST_INDEX: begin
        addr_d  = tok_raddr;
        cnt_d   = '0;
        state_d = ST_WALK;
      end
      ST_WALK: begin
        if (!stall) begin
          addr_d = tok_raddr;
          if (tok_valid) begin
            cnt_d = cnt_q + CW'(1);
            if (!skipped_q) begin
              skipped_d = 1'b1;
            end else if (emit_char) begin
              name_sent_d = name_sent_q + NW'(1);
              pend_d      = 1'b1;
              pend_char_d = tok_rdata_q;
            end
          end else begin
            codes_left_d = codes_left_q - 8'd1;
            if (codes_left_q == 8'd1) begin
              state_d = ST_TERM;
            end else begin
              pend_d  = 1'b0;
              state_d = ST_IDLE;
            end
          end
        end
      end
      ST_TERM: begin
        if (push_ready) begin
          if (pend_q) begin
            pend_d = 1'b0;
          end else begin
            awaiting_d = 1'b1;
            state_d    = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      codes_left_q <= '0;
      awaiting_q   <= 1'b1;
      skipped_q    <= 1'b0;
      name_sent_q  <= '0;
      pend_q       <= 1'b0;
    end else begin
      state_q      <= state_d;
      codes_left_q <= codes_left_d;
      awaiting_q   <= awaiting_d;
      skipped_q    <= skipped_d;
      name_sent_q  <= name_sent_d;
      pend_q       <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_char_q <= pend_char_d;
    addr_q      <= addr_d;
    cnt_q       <= cnt_d;
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && in_i.mode == MODE_TOKEN) begin
      token_store[AW'(in_i.address)] <= in_byte;
    end
    tok_rdata_q <= token_store[tok_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && in_i.mode == MODE_INDEX) begin
      index_store[in_i.address[SLOT_W-1:0]] <= in_i.value;
    end
    idx_rdata_q <= index_store[in_byte];
  end

  ste_out_buf u_out_buf (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_data_i  (push_data),
    .push_ready_o (push_ready),
    .out_o        (out_o)
  );

endmodule

`default_nettype wire

// ===== sv/ste_out_buf.sv =====
// Two-entry result buffer between the expander core and the output channel.
// Depends on ste_pkg and ste_if.
`default_nettype none

module ste_out_buf (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                push_i,
  input  wire ste_pkg::ste_result_t push_data_i,
  output logic                     push_ready_o,
  ste_out_if.source                out_o
);
  import ste_pkg::*;

  ste_result_t entry_q [2];
  logic        wr_ptr_q, wr_ptr_d;
  logic        rd_ptr_q, rd_ptr_d;
  logic [1:0]  count_q, count_d;
  logic        do_push, do_pop;

  assign push_ready_o = (count_q != 2'd2);
  assign do_push      = push_i && push_ready_o;
  assign do_pop       = out_o.valid && out_o.ready;

  assign out_o.valid         = (count_q != 2'd0);
  assign out_o.char_out      = entry_q[rd_ptr_q].char_out;
  assign out_o.end_of_symbol = entry_q[rd_ptr_q].end_of_symbol;
  assign out_o.last_of_item  = entry_q[rd_ptr_q].last_of_item;

  always_comb begin
    wr_ptr_d = do_push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = do_pop ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + 2'd1;
    end else if (!do_push && do_pop) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

`default_nettype wire

// ===== sv/ste_checker.sv =====
// Port-level checks for symbol_token_expander, attached by bind.
// Depends on ste_pkg.
`default_nettype none

module ste_checker (
  input wire logic                       clk_i,
  input wire logic                       rst_ni,
  input wire logic                       in_valid_i,
  input wire logic                       in_ready_i,
  input wire ste_pkg::ste_mode_e         in_mode_i,
  input wire logic                       out_valid_i,
  input wire logic                       out_ready_i,
  input wire logic [ste_pkg::CHAR_W-1:0] out_char_i,
  input wire logic                       out_eos_i,
  input wire logic                       out_last_i
);
  import ste_pkg::*;

  logic load_beat;
  assign load_beat = in_valid_i && in_ready_i && (in_mode_i != MODE_STREAM);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_char_i)
      && $stable(out_eos_i) && $stable(out_last_i))
    else $error("output beat changed while stalled");

  a_load_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_beat |=> in_ready_i)
    else $error("not ready after a load beat");

  a_term_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_eos_i |-> out_char_i == '0 && out_last_i)
    else $error("terminator beat malformed");

  a_char_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_eos_i |-> out_char_i != '0)
    else $error("character beat carries zero");

endmodule

bind symbol_token_expander ste_checker u_ste_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .in_mode_i   (in_i.mode),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_char_i  (out_o.char_out),
  .out_eos_i   (out_o.end_of_symbol),
  .out_last_i  (out_o.last_of_item)
);

`default_nettype wire

// ===== verif/ste_expand_check.sv =====
`timescale 1ns / 100ps
// Expansion checker for the symbol token expander: watches both channels, predicts
// the result beats of every accepted input beat and compares them in order.
// Depends on ste_pkg and the channel interfaces in ste_if.
module ste_expand_check
  import ste_pkg::*;
#(
  parameter int unsigned TOKEN_STORE_BYTES = TOKEN_STORE_BYTES_DEF,
  parameter int unsigned MAX_TOKEN_LEN     = MAX_TOKEN_LEN_DEF,
  parameter int unsigned MAX_NAME_LEN      = MAX_NAME_LEN_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  ste_in_if    in_i,
  ste_out_if   res_i,
  output int   fail_count_o,
  output int   pending_o
);

  localparam int unsigned NAME_W = $clog2(MAX_NAME_LEN);

  logic [CHAR_W-1:0]  token_mem [TOKEN_STORE_BYTES];
  logic [VALUE_W-1:0] index_mem [INDEX_SLOTS];
  logic [7:0]         codes_left;
  logic               awaiting_len;
  logic               type_skipped;
  logic [NAME_W-1:0]  name_cnt;

  ste_result_t expected_beats[$];
  ste_result_t want, got;
  int          mismatches;

  function automatic ste_result_t char_beat(logic [CHAR_W-1:0] ch, logic eos);
    return '{char_out: ch, end_of_symbol: eos, last_of_item: 1'b0};
  endfunction

  task automatic expand_item(ste_mode_e mode, logic [ADDR_W-1:0] addr,
                             logic [VALUE_W-1:0] val);
    ste_result_t       beats[$];
    int unsigned       start;
    logic [CHAR_W-1:0] ch;
    case (mode)
      MODE_TOKEN: token_mem[addr % TOKEN_STORE_BYTES] = val[CHAR_W-1:0];
      MODE_INDEX: index_mem[addr[SLOT_W-1:0]] = val;
      MODE_STREAM: begin
        if (awaiting_len) begin
          codes_left   = val[7:0];
          type_skipped = 1'b0;
          name_cnt     = '0;
          if (val[7:0] == '0) begin
            beats.push_back(char_beat('0, 1'b1));
          end else begin
            awaiting_len = 1'b0;
          end
        end else begin
          start = index_mem[val[SLOT_W-1:0]];
          for (int i = 0; i < MAX_TOKEN_LEN; i++) begin
            ch = token_mem[(start + i) % TOKEN_STORE_BYTES];
            if (ch == '0) break;
            if (!type_skipped) begin
              type_skipped = 1'b1;
            end else if (name_cnt < NAME_W'(MAX_NAME_LEN - 1)) begin
              beats.push_back(char_beat(ch, 1'b0));
              name_cnt++;
            end
          end
          codes_left--;
          if (codes_left == '0) begin
            beats.push_back(char_beat('0, 1'b1));
            awaiting_len = 1'b1;
          end
        end
      end
      default: ;  // reserved mode: ignored
    endcase
    if (beats.size() != 0) beats[beats.size()-1].last_of_item = 1'b1;
    foreach (beats[k]) expected_beats.push_back(beats[k]);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      codes_left   = '0;
      awaiting_len = 1'b1;
      type_skipped = 1'b0;
      name_cnt     = '0;
      mismatches   = 0;
      expected_beats.delete();
    end else begin
      if (res_i.valid && res_i.ready) begin
        got = '{char_out: res_i.char_out, end_of_symbol: res_i.end_of_symbol,
                last_of_item: res_i.last_of_item};
        if (expected_beats.size() == 0) begin
          if (mismatches < 10)
            $display("%0t: unexpected result beat: char %02h eos %0b last %0b",
                     $time, got.char_out, got.end_of_symbol, got.last_of_item);
          mismatches++;
        end else begin
          want = expected_beats.pop_front();
          if (got.char_out !== want.char_out || got.end_of_symbol !== want.end_of_symbol ||
              got.last_of_item !== want.last_of_item) begin
            if (mismatches < 10)
              $display("%0t: mismatch: expected char %02h eos %0b last %0b, got char %02h eos %0b last %0b",
                       $time, want.char_out, want.end_of_symbol, want.last_of_item,
                       got.char_out, got.end_of_symbol, got.last_of_item);
            mismatches++;
          end
        end
      end
      if (in_i.valid && in_i.ready) expand_item(in_i.mode, in_i.address, in_i.value);
    end
    fail_count_o <= mismatches;
    pending_o    <= expected_beats.size();
  end

endmodule

// ===== verif/tb_symbol_token_expander.sv =====
`timescale 1ns / 100ps
// Testbench top for the symbol token expander: clock, reset, directed and random
// input beats, random output stalls and the final verdict.
// Depends on ste_pkg, ste_if, symbol_token_expander and ste_expand_check.
module tb_symbol_token_expander;
  import ste_pkg::*;

  localparam int unsigned ITEM_TARGET = 230;
  localparam int unsigned IDLE_PCT    = 15;

  logic clk_i;
  logic rst_ni;
  int   fail_count;
  int   pending;
  bit   steady;
  int   items_sent;
  int   seq;
  int   pick;

  // what has been loaded so far; codes are only sent where the whole walk is loaded
  logic [CHAR_W-1:0]  shadow_tok [TOKEN_STORE_BYTES_DEF];
  bit                 tok_loaded [TOKEN_STORE_BYTES_DEF];
  logic [VALUE_W-1:0] shadow_idx [INDEX_SLOTS];
  bit                 idx_loaded [INDEX_SLOTS];

  ste_in_if  in_if ();
  ste_out_if out_if ();

  symbol_token_expander DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  ste_expand_check expand_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_if),
    .res_i        (out_if),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    out_if.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
  end

  task automatic send_beat(ste_mode_e mode, logic [ADDR_W-1:0] addr,
                           logic [VALUE_W-1:0] val);
    while (!steady && $urandom_range(99) < IDLE_PCT) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid   <= 1'b1;
    in_if.mode    <= mode;
    in_if.address <= addr;
    in_if.value   <= val;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    case (mode)
      MODE_TOKEN: begin
        shadow_tok[addr] = val[CHAR_W-1:0];
        tok_loaded[addr] = 1'b1;
      end
      MODE_INDEX: begin
        shadow_idx[addr[SLOT_W-1:0]] = val;
        idx_loaded[addr[SLOT_W-1:0]] = 1'b1;
      end
      default: ;
    endcase
    items_sent++;
  endtask

  function automatic bit walk_ok(logic [SLOT_W-1:0] slot);
    int unsigned a;
    if (!idx_loaded[slot]) return 1'b0;
    for (int i = 0; i <= MAX_TOKEN_LEN_DEF; i++) begin
      a = (shadow_idx[slot] + i) % TOKEN_STORE_BYTES_DEF;
      if (!tok_loaded[a]) return 1'b0;
      if (shadow_tok[a] == '0) return 1'b1;
    end
    return 1'b1;
  endfunction

  task automatic pick_code(output logic [SLOT_W-1:0] code);
    logic [ADDR_W-1:0] spot;
    for (int tries = 0; tries < 64; tries++) begin
      code = SLOT_W'($urandom_range(255));
      if (walk_ok(code)) return;
    end
    // no usable slot found: point this one at a fresh empty token
    spot = ADDR_W'($urandom_range(4095));
    send_beat(MODE_TOKEN, spot, {4'($urandom_range(15)), 8'h00});
    send_beat(MODE_INDEX, {4'($urandom_range(15)), code}, spot);
  endtask

  task automatic send_noise();
    case ($urandom_range(2))
      0:       send_beat(MODE_RSVD, 12'($urandom), 12'($urandom));
      1:       send_beat(MODE_TOKEN, 12'($urandom), 12'($urandom));
      default: send_beat(MODE_INDEX, 12'($urandom), 12'($urandom));
    endcase
  endtask

  task automatic define_token();
    int unsigned       len;
    logic [ADDR_W-1:0] start;
    len   = ($urandom_range(3) == 0) ? $urandom_range(40, 30) : $urandom_range(10);
    start = ADDR_W'($urandom_range(4095));
    for (int i = 0; i < len; i++)
      send_beat(MODE_TOKEN, ADDR_W'(start + i),
                {4'($urandom_range(15)), 8'($urandom_range(255, 1))});
    send_beat(MODE_TOKEN, ADDR_W'(start + len), {4'($urandom_range(15)), 8'h00});
    send_beat(MODE_INDEX, 12'($urandom), start);
  endtask

  task automatic send_record();
    int unsigned       n;
    logic [SLOT_W-1:0] code;
    case ($urandom_range(7))
      0:       n = 0;
      1:       n = $urandom_range(10, 6);
      default: n = $urandom_range(4, 1);
    endcase
    send_beat(MODE_STREAM, 12'($urandom), {4'($urandom_range(15)), 8'(n)});
    repeat (n) begin
      if ($urandom_range(7) == 0) send_noise();
      pick_code(code);
      send_beat(MODE_STREAM, 12'($urandom), {4'($urandom_range(15)), code});
    end
  endtask

  initial begin
    in_if.valid   = 1'b0;
    in_if.mode    = MODE_TOKEN;
    in_if.address = '0;
    in_if.value   = '0;
    rst_ni        = 1'b0;
    steady        = 1'b0;
    items_sent    = 0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_beat(MODE_RSVD,   12'hFFF, 12'hFFF);
    // type letter at the top of the store, token wraps to address 0
    send_beat(MODE_TOKEN,  12'hFFE, 12'hA54);
    send_beat(MODE_TOKEN,  12'hFFF, 12'h361);
    send_beat(MODE_TOKEN,  12'h000, 12'h062);
    send_beat(MODE_TOKEN,  12'h001, 12'hF00);
    send_beat(MODE_INDEX,  12'hEFF, 12'hFFE);
    send_beat(MODE_INDEX,  12'h100, 12'h001);
    send_beat(MODE_STREAM, 12'hABC, 12'hF00);
    send_beat(MODE_STREAM, 12'h000, 12'h002);
    send_beat(MODE_STREAM, 12'hFFF, 12'hEFF);
    send_beat(MODE_STREAM, 12'h555, 12'h0FF);
    // empty first token: the type letter is skipped in the later one
    send_beat(MODE_STREAM, 12'h000, 12'h503);
    send_beat(MODE_STREAM, 12'h000, 12'h000);
    send_beat(MODE_RSVD,   12'h000, 12'h000);
    send_beat(MODE_STREAM, 12'h000, 12'h100);
    send_beat(MODE_STREAM, 12'h000, 12'h7FF);

    seq = 0;
    while (items_sent < ITEM_TARGET) begin
      steady <= (seq >= 12 && seq < 30);
      pick = $urandom_range(99);
      if (pick < 25) define_token();
      else if (pick < 80) send_record();
      else send_noise();
      seq++;
    end
    steady      <= 1'b0;
    in_if.valid <= 1'b0;

    do @(posedge clk_i); while (pending != 0);
    repeat (MAX_TOKEN_LEN_DEF + 8) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule
